### rtl/mnva_pkg.sv
// Shared types and constants of the MIDI note voice allocator.
package mnva_pkg;

  // Number of voice channels and width of a voice index
  localparam int unsigned Voices = 6;
  localparam int unsigned IdxW   = (Voices > 1) ? $clog2(Voices) : 1;

  // Field widths
  localparam int unsigned CmdW   = 2;
  localparam int unsigned ChanW  = 4;
  localparam int unsigned KeyW   = 7;
  localparam int unsigned VelW   = 7;
  localparam int unsigned HeldW  = 8;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDatW = 4;

  // Free marker, above every note number
  localparam logic [HeldW-1:0] FreeMark = 8'd129;

  // Input event kinds; code 3 means nothing and is caught by default arms
  typedef enum logic [CmdW-1:0] {
    CMD_NOTE_ON  = 2'd0,
    CMD_NOTE_OFF = 2'd1,
    CMD_OTHER    = 2'd2
  } cmd_e;

  // Output event kinds
  typedef enum logic [0:0] {
    KIND_NOTE_ON  = 1'b0,
    KIND_NOTE_OFF = 1'b1
  } kind_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_BASE_CHANNEL   = 4'd0,
    REG_LISTEN_CHANNEL = 4'd1
  } reg_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_FINISH = 2'd2
  } state_e;

endpackage

### rtl/mnva_in_if.sv
// Input event channel of the voice allocator.
interface mnva_in_if;
  logic                           valid;
  logic                           ready;
  logic [mnva_pkg::CmdW-1:0]      cmd;
  logic [mnva_pkg::ChanW-1:0]     in_channel;
  logic [mnva_pkg::KeyW-1:0]      key;
  logic [mnva_pkg::VelW-1:0]      velocity;

  modport source (output valid, cmd, in_channel, key, velocity, input ready);
  modport sink   (input valid, cmd, in_channel, key, velocity, output ready);
endinterface

### rtl/mnva_out_if.sv
// Output event channel of the voice allocator.
interface mnva_out_if;
  logic                           valid;
  logic                           ready;
  logic                           out_kind;
  logic [mnva_pkg::ChanW-1:0]     out_channel;
  logic [mnva_pkg::KeyW-1:0]      out_key;
  logic [mnva_pkg::VelW-1:0]      out_velocity;

  modport source (output valid, out_kind, out_channel, out_key, out_velocity, input ready);
  modport sink   (input valid, out_kind, out_channel, out_key, out_velocity, output ready);
endinterface

### rtl/mnva_cfg_if.sv
// Configuration write channel of the voice allocator.
interface mnva_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mnva_pkg::CfgIdxW-1:0]   index;
  logic [mnva_pkg::CfgDatW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/midi_note_voice_allocator_top.sv
// Polyphonic MIDI voice allocator: top level with scan sequencer and voice table.
//
// Note-on and note-off beats on the listened channel are spread over six voice
// channels. An accepted beat that is handled is captured, the six voices of the
// voice table are then scanned one voice per cycle through the shared compare
// unit, and then the table is updated and the output register loaded. An
// unmatched note-off goes through the same steps and leaves no result. Beats on
// other channels and other event kinds leave no result and keep the input
// ready. The output register holds one result, so the input is taken again
// while that result still waits; a later result waits in the final step until
// the output register is free. Configuration writes are always accepted and
// are meant for idle periods only.
module midi_note_voice_allocator_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  mnva_in_if.sink        in_i,
  mnva_out_if.source     out_o,
  mnva_cfg_if.sink       cfg_i
);

  // Configuration registers
  logic [mnva_pkg::ChanW-1:0] base_q, listen_q;

  // Voice table and rotation pointer
  logic [mnva_pkg::HeldW-1:0] held_q [mnva_pkg::Voices];
  logic [mnva_pkg::IdxW-1:0]  ptr_q;

  // Sequencer and captured beat
  mnva_pkg::state_e           state_q, state_d;
  logic                       is_off_q;
  logic [mnva_pkg::KeyW-1:0]  key_q;
  logic [mnva_pkg::VelW-1:0]  vel_q;
  logic [mnva_pkg::IdxW-1:0]  cnt_q;

  // Scan results
  logic [mnva_pkg::IdxW-1:0]  sel_q;
  logic [mnva_pkg::HeldW-1:0] best_q;
  logic [mnva_pkg::HeldW-1:0] ptr_val_q;
  logic                       found_q;

  // Output register
  logic                       out_valid_q;
  logic                       out_kind_q;
  logic [mnva_pkg::ChanW-1:0] out_chan_q;
  logic [mnva_pkg::KeyW-1:0]  out_key_q;
  logic [mnva_pkg::VelW-1:0]  out_vel_q;

  logic                       in_beat, out_beat, take, last, out_free, emit, commit;
  logic [mnva_pkg::HeldW-1:0] cur, key_ext;
  logic                       cur_gt, cur_eq;
  logic [mnva_pkg::IdxW-1:0]  final_sel, next_ptr;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == mnva_pkg::ST_IDLE);
  assign in_beat     = in_i.valid && in_i.ready;
  assign out_beat    = out_valid_q && out_o.ready;

  // A beat is worked on only when it is on the listened channel and a note event
  always_comb begin
    case (in_i.cmd)
      mnva_pkg::CMD_NOTE_ON,
      mnva_pkg::CMD_NOTE_OFF: take = (in_i.in_channel == listen_q);
      default:                take = 1'b0;
    endcase
  end

  // Shared compare unit on the voice under scan
  assign cur     = held_q[cnt_q];
  assign key_ext = {1'b0, key_q};
  assign cur_gt  = (cur > best_q);
  assign cur_eq  = (cur == key_ext);
  assign last    = (cnt_q == mnva_pkg::IdxW'(mnva_pkg::Voices - 1));

  // Voice choice: the pointer's voice wins a tie for the maximum
  assign final_sel = (!is_off_q && (ptr_val_q == best_q)) ? ptr_q : sel_q;
  assign next_ptr  = (final_sel == mnva_pkg::IdxW'(mnva_pkg::Voices - 1))
                     ? '0 : final_sel + mnva_pkg::IdxW'(1);

  assign out_free = !out_valid_q || out_o.ready;
  assign emit     = !is_off_q || found_q;
  assign commit   = (state_q == mnva_pkg::ST_FINISH) && out_free;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mnva_pkg::ST_IDLE:   if (in_beat && take) state_d = mnva_pkg::ST_SCAN;
      mnva_pkg::ST_SCAN:   if (last) state_d = mnva_pkg::ST_FINISH;
      mnva_pkg::ST_FINISH: if (out_free) state_d = mnva_pkg::ST_IDLE;
      default:             state_d = mnva_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mnva_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      listen_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        mnva_pkg::REG_BASE_CHANNEL:   base_q   <= cfg_i.data;
        mnva_pkg::REG_LISTEN_CHANNEL: listen_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Capture of the accepted beat
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      is_off_q <= (in_i.cmd == mnva_pkg::CMD_NOTE_OFF);
      key_q    <= in_i.key;
      vel_q    <= in_i.velocity;
    end
  end

  // Scan counter and running results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      sel_q     <= '0;
      best_q    <= '0;
      ptr_val_q <= '0;
      found_q   <= 1'b0;
    end else if (in_beat) begin
      cnt_q   <= '0;
      found_q <= 1'b0;
    end else if (state_q == mnva_pkg::ST_SCAN) begin
      cnt_q <= last ? '0 : cnt_q + mnva_pkg::IdxW'(1);
      if (cnt_q == ptr_q) begin
        ptr_val_q <= cur;
      end
      if (is_off_q) begin
        if (!found_q && cur_eq) begin
          sel_q   <= cnt_q;
          found_q <= 1'b1;
        end
      end else if (cnt_q == '0 || cur_gt) begin
        sel_q  <= cnt_q;
        best_q <= cur;
      end
    end
  end

  // Voice table and pointer update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(mnva_pkg::Voices); i++) begin
        held_q[i] <= mnva_pkg::FreeMark;
      end
      ptr_q <= '0;
    end else if (commit && emit) begin
      if (is_off_q) begin
        held_q[final_sel] <= mnva_pkg::FreeMark;
      end else begin
        held_q[final_sel] <= key_ext;
        ptr_q             <= next_ptr;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_beat) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit && emit) begin
      out_kind_q <= is_off_q ? mnva_pkg::KIND_NOTE_OFF : mnva_pkg::KIND_NOTE_ON;
      out_chan_q <= base_q + mnva_pkg::ChanW'(final_sel);
      out_key_q  <= key_q;
      out_vel_q  <= vel_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_kind     = out_kind_q;
  assign out_o.out_channel  = out_chan_q;
  assign out_o.out_key      = out_key_q;
  assign out_o.out_velocity = out_vel_q;

`ifndef SYNTH
  // Pointer always names a real voice
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q < mnva_pkg::IdxW'(mnva_pkg::Voices))
    else $error("rotation pointer out of range");

  // Scan counter stays within the table
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < mnva_pkg::IdxW'(mnva_pkg::Voices))
    else $error("scan counter out of range");

  // A note-on result stores its key in the chosen voice
  a_note_on_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && !is_off_q) |=> held_q[$past(final_sel)] == $past(key_ext))
    else $error("note-on key not stored");

  // A note-off result frees the voice it names
  a_note_off_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && is_off_q && found_q) |=> held_q[$past(final_sel)] == mnva_pkg::FreeMark)
    else $error("note-off voice not freed");

  // A finished result never overwrites one still waiting
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && emit) |-> out_free)
    else $error("output register overrun");
`endif

endmodule
